/* rtl/amed_pkg.sv */
// Shared types, constants and helper functions for the motion event detector.
package amed_pkg;

   localparam int unsigned SampleWidth = 12;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 2;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic        [SampleWidth-1:0] delta_type;
   typedef logic        [1:0]             level_type;
   typedef logic        [ByteWidth-1:0]   byte_type;

   // Configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CsrSensorEnabled    = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrSensitivityLevel = 1'b1;

   // Sensitivity level codes
   localparam level_type LevelOff    = 2'd0;
   localparam level_type LevelLow    = 2'd1;
   localparam level_type LevelMedium = 2'd2;
   localparam level_type LevelHigh   = 2'd3;

   localparam delta_type LimitOff    = 12'hFFF;
   localparam delta_type LimitLow    = 12'd600;
   localparam delta_type LimitMedium = 12'd400;
   localparam delta_type LimitHigh   = 12'd300;
   localparam delta_type LimitShake  = 12'd120;

   // Decoded result of one request
   typedef struct packed {
      sample_type x_sample;
      sample_type y_sample;
      sample_type z_sample;
      logic       crash_flag;
      logic       shake_flag;
   } result_type;

   // Sample is {high byte, upper nibble of low byte}, two's complement.
   function automatic sample_type decode_sample(input byte_type low_byte,
                                                input byte_type high_byte);
      decode_sample = sample_type'({high_byte, low_byte[7:4]});
   endfunction

   // Exact |a - b|, 0 to 4095.
   function automatic delta_type abs_delta(input sample_type a, input sample_type b);
      logic [SampleWidth:0] diff;
      logic [SampleWidth:0] mag;
      diff = {a[SampleWidth-1], a} - {b[SampleWidth-1], b};
      mag  = diff[SampleWidth] ? (~diff + 1'b1) : diff;
      abs_delta = mag[SampleWidth-1:0];
   endfunction

   function automatic delta_type crash_limit(input level_type level);
      case (level)
         LevelLow:    crash_limit = LimitLow;
         LevelMedium: crash_limit = LimitMedium;
         LevelHigh:   crash_limit = LimitHigh;
         default:     crash_limit = LimitOff;
      endcase
   endfunction

   // True when at least two of the three inputs are set.
   function automatic logic two_of_three(input logic a, input logic b, input logic c);
      two_of_three = (a & b) | (a & c) | (b & c);
   endfunction

endpackage

/* rtl/accel_motion_event_detector.sv */
// Top level of the accelerometer motion event detector.
// Each request carries the six raw output bytes of a 12-bit three-axis
// accelerometer and yields exactly one response with the decoded signed
// samples plus a crash and a shake flag. Crash is set when two or more axes
// moved by more than the sensitivity threshold (600, 400 or 300 counts; never
// when the level is off); shake is set when two or more axes moved by more
// than 120 counts. Movement is the exact absolute difference to the samples
// stored by the previous request that arrived while the sensor was enabled.
// With the sensor disabled both flags read 0 and the stored samples hold.
// The block is a two-register pipeline: a request register, then one level
// of subtract, absolute value and compare logic, then the response register.
// A request accepted into the request register moves on into the response
// register, which drives rsp_tvalid, once that slot is free or draining.
// One request is taken every cycle as long as the response side keeps up;
// with the response side stalled the block holds at most two requests. The
// stored previous samples are updated in the same edge that moves a request
// into the response register, so a following request sees them at once.
// Write configuration only while no request is in flight.
module accel_motion_event_detector
   import amed_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // configuration write port
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
   input  logic [47:0]              req_tdata,
   // response channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // x_sample, y_sample, z_sample, crash_flag, shake_flag, 2 zero pad bits
   output logic [39:0]              rsp_tdata
);

   // Configuration registers
   logic      enabled_ff, enabled_in;
   level_type level_ff, level_in;

   // Request register
   logic        req_valid_ff, req_valid_in;
   logic [47:0] req_data_ff, req_data_in;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   // Stored samples from the last enabled request
   sample_type prev_x_ff, prev_x_in;
   sample_type prev_y_ff, prev_y_in;
   sample_type prev_z_ff, prev_z_in;

   logic       advance;
   sample_type x_cur, y_cur, z_cur;
   delta_type  dx, dy, dz, limit;
   logic       crash, shake;

   // Move the held request forward when the response slot is free or draining.
   assign advance    = req_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~req_valid_ff | advance;

   // Decode and compare
   always_comb begin
      x_cur = decode_sample(req_data_ff[7:0],   req_data_ff[15:8]);
      y_cur = decode_sample(req_data_ff[23:16], req_data_ff[31:24]);
      z_cur = decode_sample(req_data_ff[39:32], req_data_ff[47:40]);
      dx    = abs_delta(x_cur, prev_x_ff);
      dy    = abs_delta(y_cur, prev_y_ff);
      dz    = abs_delta(z_cur, prev_z_ff);
      limit = crash_limit(level_ff);
      crash = enabled_ff & (level_ff != LevelOff)
            & two_of_three(dx > limit, dy > limit, dz > limit);
      shake = enabled_ff
            & two_of_three(dx > LimitShake, dy > LimitShake, dz > LimitShake);
   end

   // Next-state logic
   always_comb begin
      enabled_in   = enabled_ff;
      level_in     = level_ff;
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_z_in    = prev_z_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CsrSensorEnabled:    enabled_in = csr_data[0];
            CsrSensitivityLevel: level_in   = csr_data[1:0];
            default: ;
         endcase
      end

      // drain the response, then refill from the request register
      if (rsp_valid_ff & rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in       = 1'b1;
         rsp_in.x_sample    = x_cur;
         rsp_in.y_sample    = y_cur;
         rsp_in.z_sample    = z_cur;
         rsp_in.crash_flag  = crash;
         rsp_in.shake_flag  = shake;
         req_valid_in       = 1'b0;
         if (enabled_ff) begin
            prev_x_in = x_cur;
            prev_y_in = y_cur;
            prev_z_in = z_cur;
         end
      end

      // take a new request
      if (req_tvalid & req_tready) begin
         req_valid_in = 1'b1;
         req_data_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         level_ff     <= LevelOff;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
      end else begin
         enabled_ff   <= enabled_in;
         level_ff     <= level_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         prev_z_ff    <= prev_z_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.shake_flag, rsp_ff.crash_flag,
                        rsp_ff.z_sample, rsp_ff.y_sample, rsp_ff.x_sample};

   // A flagged response needs the sensor enabled; crash also needs a level.
   a_flags_need_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff & (rsp_ff.crash_flag | rsp_ff.shake_flag) |-> enabled_ff)
      else $error("motion flag raised while sensor disabled");

   a_crash_needs_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff & rsp_ff.crash_flag |-> level_ff != LevelOff)
      else $error("crash flag raised with sensitivity off");

   // An enabled request that moves forward leaves its samples as the new history.
   a_history_update: assert property (@(posedge clock) disable iff (reset)
      advance & enabled_ff |=> prev_x_ff == rsp_ff.x_sample
                             && prev_y_ff == rsp_ff.y_sample
                             && prev_z_ff == rsp_ff.z_sample)
      else $error("stored samples do not match forwarded response");

   // Back-pressure on requests only while a request is held.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> req_valid_ff & rsp_valid_ff & !rsp_tready)
      else $error("request side stalled without a held request");

endmodule
